// File: rtl/wbbu_pkg.sv
// Shared constants and types for the windowed bin bias update block.
package wbbu_pkg;

  localparam int NUM_BINS  = 256;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int NBINS_W   = 9;
  localparam int MAX_TAPS  = 4;
  localparam int TAP_IDX_W = 2;
  localparam int WLEN_W    = 3;
  localparam int AMP_W     = 24;
  localparam int TAP_W     = 17;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = AMP_W + TAP_W;
  localparam int ADDR_EXT_W = NBINS_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ZERO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_THREE   = 3'd6;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             en;
    logic [BIN_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } store_wr_t;

endpackage

// File: rtl/wbbu_store.sv
// Bin bias memory with per-bin valid bits and write-to-read bypass.
module wbbu_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [wbbu_pkg::BIN_W-1:0]     rd_addr,
  input  wbbu_pkg::store_wr_t            wr,
  output logic [wbbu_pkg::VAL_W-1:0]     rd_data
);
  import wbbu_pkg::*;

  logic [VAL_W-1:0]    mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid_r;
  logic [VAL_W-1:0]    mem_q_r;
  logic                vb_r;
  logic                byp_hit_r;
  logic [VAL_W-1:0]    byp_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // a bin never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      vb_r      <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vb_r      <= valid_r[rd_addr];
        byp_hit_r <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr.data;
    end
  end

  always_comb begin
    if (byp_hit_r) begin
      rd_data = byp_data_r;
    end else if (vb_r) begin
      rd_data = mem_q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// File: rtl/windowed_bin_bias_update.sv
// Top level: windowed bias update sequencer over a single bin memory.
// Sequence per item: m bin accesses (read: 1; update: up to 2*window-1) at one
//   read-modify-write per cycle, the drain of the two-stage update pipeline, the handoff;
//   an out-of-range index skips the accesses and the drain. A new item is accepted only
//   once the result of the last one is loaded into the output register.
// Reset: all bins read as zero at once (valid bits cleared), config registers
//   take their defaults, no clearing pass.
module windowed_bin_bias_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [wbbu_pkg::BIN_W-1:0]        in_bin_index,
  input  logic [wbbu_pkg::AMP_W-1:0]        in_amplitude,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wbbu_pkg::VAL_W-1:0] out_bin_value,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbbu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbbu_pkg::TAP_W-1:0]        cfg_data
);
  import wbbu_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // configuration
  logic [NBINS_W-1:0] bins_in_use_r;
  logic [WLEN_W-1:0]  window_len_r;
  logic               periodic_r;
  logic [TAP_W-1:0]   taps_r [MAX_TAPS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_in_use_r <= NBINS_W'(NUM_BINS);
      window_len_r  <= WLEN_W'(1);
      periodic_r    <= 1'b0;
      taps_r[0]     <= TAP_W'(65536);
      taps_r[1]     <= '0;
      taps_r[2]     <= '0;
      taps_r[3]     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BINS_IN_USE: bins_in_use_r <= cfg_data[NBINS_W-1:0];
        REG_WINDOW_LEN:  window_len_r  <= cfg_data[WLEN_W-1:0];
        REG_PERIODIC:    periodic_r    <= cfg_data[0];
        REG_TAP_ZERO:    taps_r[0]     <= cfg_data;
        REG_TAP_ONE:     taps_r[1]     <= cfg_data;
        REG_TAP_TWO:     taps_r[2]     <= cfg_data;
        REG_TAP_THREE:   taps_r[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective bin count and window length at accept
  logic [NBINS_W-1:0] n_eff;
  logic [WLEN_W-1:0]  w_eff;

  always_comb begin
    n_eff = bins_in_use_r;
    if (n_eff == '0) begin
      n_eff = NBINS_W'(1);
    end else if (n_eff > NBINS_W'(NUM_BINS)) begin
      n_eff = NBINS_W'(NUM_BINS);
    end
    w_eff = window_len_r;
    if (w_eff > WLEN_W'(MAX_TAPS)) begin
      w_eff = WLEN_W'(MAX_TAPS);
    end
    if ({{(NBINS_W-WLEN_W){1'b0}}, w_eff} > n_eff) begin
      w_eff = n_eff[WLEN_W-1:0];
    end
    if (in_func == FUNC_READ) begin
      w_eff = WLEN_W'(1);
    end
  end

  // item and sequencer state
  logic [1:0]           state_r, state_nxt;
  logic [BIN_W-1:0]     i_r;
  logic [AMP_W-1:0]     amp_r;
  logic                 func_r;
  logic [NBINS_W-1:0]   n_r;
  logic [WLEN_W-1:0]    w_r;
  logic [TAP_IDX_W-1:0] j_r;
  logic                 side_r;
  logic                 in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // neighbor address
  logic [ADDR_EXT_W-1:0] i_x, j_x, n_x, s_x, k_x;
  logic                  skip;
  logic [WLEN_W-1:0]     j_next;
  logic [TAP_IDX_W-1:0]  j_step_nxt;
  logic                  side_step_nxt;
  logic                  last_issue;
  logic [BIN_W-1:0]      rd_addr;
  logic                  issue;

  always_comb begin
    i_x  = ADDR_EXT_W'(i_r);
    j_x  = ADDR_EXT_W'(j_r);
    n_x  = ADDR_EXT_W'(n_r);
    s_x  = i_x + j_x;
    skip = periodic_r && ({j_x[ADDR_EXT_W-2:0], 1'b0} == n_x);
    if (j_r == '0) begin
      k_x = i_x;
    end else if (!side_r) begin
      if (i_x >= j_x) begin
        k_x = i_x - j_x;
      end else if (periodic_r) begin
        k_x = i_x + n_x - j_x;
      end else begin
        k_x = j_x - i_x - ADDR_EXT_W'(1);
      end
    end else begin
      if (s_x < n_x) begin
        k_x = s_x;
      end else if (periodic_r) begin
        k_x = s_x - n_x;
      end else begin
        k_x = {n_x[ADDR_EXT_W-2:0], 1'b0} - ADDR_EXT_W'(1) - s_x;
      end
    end
    rd_addr = k_x[BIN_W-1:0];

    // advance: centre, then minus/plus for each offset
    j_next        = WLEN_W'(j_r) + WLEN_W'(1);
    j_step_nxt    = j_r;
    side_step_nxt = 1'b0;
    if (j_r == '0 || side_r || skip) begin
      last_issue    = (j_next >= w_r);
      j_step_nxt    = j_next[TAP_IDX_W-1:0];
      side_step_nxt = 1'b0;
    end else begin
      last_issue    = 1'b0;
      side_step_nxt = 1'b1;
    end
  end

  assign issue = (state_r == ST_RUN);

  // stage A: read issue and product
  logic                 a_vld_r;
  logic [BIN_W-1:0]     a_addr_r;
  logic [PROD_W-1:0]    prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_addr_r <= rd_addr;
      prod_r   <= (func_r == FUNC_READ) ? '0 : PROD_W'(amp_r) * PROD_W'(taps_r[j_r]);
    end
  end

  // stage B: round, add, clip, write back
  logic [VAL_W-1:0]   old_val;
  logic [PROD_W:0]    rnd;
  logic [VAL_W:0]     sum_x;
  logic [VAL_W-1:0]   new_val;
  logic               clip;
  store_wr_t          wr;

  wbbu_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (old_val)
  );

  always_comb begin
    rnd   = {1'b0, prod_r} + (PROD_W+1)'(32768);
    sum_x = {old_val[VAL_W-1], old_val} + (VAL_W+1)'(rnd[PROD_W:16]);
    clip  = 1'b0;
    new_val = sum_x[VAL_W-1:0];
    if (sum_x[VAL_W:VAL_W-1] == 2'b01) begin
      new_val = VAL_MAX;
      clip    = 1'b1;
    end else if (sum_x[VAL_W:VAL_W-1] == 2'b10) begin
      new_val = VAL_MIN;
      clip    = 1'b1;
    end
    wr.en   = a_vld_r;
    wr.addr = a_addr_r;
    wr.data = new_val;
  end

  logic [VAL_W-1:0] center_r;
  logic             sat_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      center_r <= '0;
      sat_r    <= 1'b0;
    end else if (a_vld_r) begin
      if (a_addr_r == i_r) begin
        center_r <= new_val;
      end
      sat_r <= sat_r | clip;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      i_r    <= in_bin_index;
      amp_r  <= in_amplitude;
      func_r <= in_func;
      n_r    <= n_eff;
      w_r    <= w_eff;
    end
  end

  // sequencer
  logic out_load;
  assign out_load = (state_r == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // skip the accesses for an index outside the active bins
          state_nxt = ({1'b0, in_bin_index} < n_eff) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        j_r    <= '0;
        side_r <= 1'b0;
      end else if (issue) begin
        j_r    <= j_step_nxt;
        side_r <= side_step_nxt;
      end
    end
  end

  // output word register
  logic             out_valid_r;
  logic [VAL_W-1:0] out_bin_value_r;
  logic             out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_value_r <= center_r;
      out_saturated_r <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_value = out_bin_value_r;
  assign out_saturated = out_saturated_r;

  // no write back pending while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !a_vld_r)
    else $error("write back active while idle");

  // the first access of an item targets its centre bin
  a_centre_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && j_r == '0) |-> (rd_addr == i_r))
    else $error("first access not at centre bin");

  // every write lands inside the active bins
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> ({1'b0, a_addr_r} < n_r))
    else $error("write outside active bins");

endmodule

// File: bench/windowed_bin_bias_update_test.sv
// Self-checking bench for the windowed bin bias update block: directed table, then random phases.
module windowed_bin_bias_update_test;
  import wbbu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int STALL_PCT      = 19;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int PHASE_WORDS    = 153;
  localparam int PLAN_ROWS      = 37;
  localparam int TAP_ONE_Q16    = 65536;
  localparam int TAP_TOP        = 131071;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } bin_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // sel is func or register index, arg is bin or register data
  typedef struct {
    row_kind_t kind;
    int        sel;
    int        arg;
    int        amp;
    bit        typed;
    int        val;
    bit        sat;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_func = FUNC_UPDATE;
  logic [BIN_W-1:0]        in_bin_index = '0;
  logic [AMP_W-1:0]        in_amplitude = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_bin_value;
  logic                    out_saturated;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_BINS_IN_USE;
  logic [TAP_W-1:0]        cfg_data = '0;

  // mirror of the block state and its registers
  logic signed [VAL_W-1:0] bias_mirror [NUM_BINS];
  logic [NBINS_W-1:0]      mirror_bins;
  logic [WLEN_W-1:0]       mirror_wlen;
  logic                    mirror_periodic;
  logic [TAP_W-1:0]        mirror_taps [MAX_TAPS];

  bin_result_t pending_bins [$];
  bin_result_t head_bin;
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_WORD, FUNC_READ,       255, 0,         1, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     0,   0,         1, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     7,   'hFFFFFF,  1, 'hFFFFFF,  0},
    '{ROW_WORD, FUNC_READ,       7,   0,         1, 'hFFFFFF,  0},
    '{ROW_WORD, FUNC_UPDATE,     7,   'h000001,  0, 0,         0},
    '{ROW_REG,  REG_BINS_IN_USE, 4,      0, 0, 0, 0},
    '{ROW_REG,  REG_WINDOW_LEN,  4,      0, 0, 0, 0},
    '{ROW_REG,  REG_PERIODIC,    1,      0, 0, 0, 0},
    '{ROW_REG,  REG_TAP_ONE,     65536,  0, 0, 0, 0},
    '{ROW_REG,  REG_TAP_TWO,     32768,  0, 0, 0, 0},
    '{ROW_REG,  REG_TAP_THREE,   131071, 0, 0, 0, 0},
    // wrap, opposite bin hit once
    '{ROW_WORD, FUNC_UPDATE,     0,   'h010000,  0, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     3,   'hABCDEF,  0, 0,         0},
    '{ROW_WORD, FUNC_READ,       4,   0,         1, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     255, 'hFFFFFF,  1, 0,         0},
    '{ROW_REG,  REG_PERIODIC,    0,      0, 0, 0, 0},
    // reflect at both edges
    '{ROW_WORD, FUNC_UPDATE,     0,   'h123456,  0, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     3,   'h00FFFF,  0, 0,         0},
    '{ROW_REG,  REG_BINS_IN_USE, 3,      0, 0, 0, 0},
    '{ROW_WORD, FUNC_UPDATE,     1,   'h020000,  0, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     2,   'h020000,  0, 0,         0},
    // zero bins acts as one, long window clipped
    '{ROW_REG,  REG_BINS_IN_USE, 0,      0, 0, 0, 0},
    '{ROW_REG,  REG_WINDOW_LEN,  7,      0, 0, 0, 0},
    '{ROW_WORD, FUNC_UPDATE,     0,   'hFFFFFF,  0, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     1,   'h000100,  1, 0,         0},
    '{ROW_REG,  REG_BINS_IN_USE, 2,      0, 0, 0, 0},
    '{ROW_REG,  REG_PERIODIC,    1,      0, 0, 0, 0},
    '{ROW_WORD, FUNC_UPDATE,     1,   'h030000,  0, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     0,   0,         0, 0,         0},
    // oversized bin count, zero window, tap above one
    '{ROW_REG,  REG_BINS_IN_USE, 511,    0, 0, 0, 0},
    '{ROW_REG,  REG_WINDOW_LEN,  0,      0, 0, 0, 0},
    '{ROW_REG,  REG_TAP_ZERO,    131071, 0, 0, 0, 0},
    '{ROW_WORD, FUNC_UPDATE,     255, 'hFFFFFF,  0, 0,         0},
    '{ROW_WORD, FUNC_UPDATE,     128, 'h800000,  0, 0,         0},
    '{ROW_REG,  REG_SPARE,       131071, 0, 0, 0, 0},
    '{ROW_WORD, FUNC_READ,       1,   0,         0, 0,         0},
    '{ROW_WORD, FUNC_READ,       128, 0,         0, 0,         0}
  };

  windowed_bin_bias_update dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_bin_index  (in_bin_index),
    .in_amplitude  (in_amplitude),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_value (out_bin_value),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int mirror_span();
    int n;
    n = mirror_bins;
    if (n < 1) n = 1;
    if (n > NUM_BINS) n = NUM_BINS;
    return n;
  endfunction

  // add amp*tap (tap in Q1.16), rounded to an integer, into one bin; return 1 on clip
  function automatic bit accumulate(int k, longint amp, longint tap);
    longint term;
    longint sum;
    bit     clip;
    clip = 1'b0;
    term = (amp * tap + 64'sd32768) >>> 16;
    sum = longint'(bias_mirror[k]) + term;
    if (sum > longint'(signed'(VAL_MAX))) begin
      sum = longint'(signed'(VAL_MAX));
      clip = 1'b1;
    end
    if (sum < longint'(signed'(VAL_MIN))) begin
      sum = longint'(signed'(VAL_MIN));
      clip = 1'b1;
    end
    bias_mirror[k] = sum[VAL_W-1:0];
    return clip;
  endfunction

  function automatic void predict_bin(input logic func, input int idx, input longint amp,
                                      output bin_result_t res);
    int n;
    int w;
    int j;
    int k;
    n = mirror_span();
    res = '0;
    if (idx >= n) return;
    if (func == FUNC_UPDATE) begin
      w = mirror_wlen;
      if (w > MAX_TAPS) w = MAX_TAPS;
      if (w > n) w = n;
      res.sat = accumulate(idx, amp, mirror_taps[0]);
      for (j = 1; j < w; j++) begin
        if (idx >= j) k = idx - j;
        else k = mirror_periodic ? idx + n - j : j - idx - 1;
        res.sat |= accumulate(k, amp, mirror_taps[j]);
        // skip the plus side when it lands on the same opposite bin
        if (!(mirror_periodic && 2 * j == n)) begin
          k = idx + j;
          if (k >= n) k = mirror_periodic ? k - n : 2 * n - 1 - k;
          res.sat |= accumulate(k, amp, mirror_taps[j]);
        end
      end
    end
    res.value = bias_mirror[idx];
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [TAP_W-1:0] data);
    case (idx)
      REG_BINS_IN_USE: mirror_bins = data[NBINS_W-1:0];
      REG_WINDOW_LEN:  mirror_wlen = data[WLEN_W-1:0];
      REG_PERIODIC:    mirror_periodic = data[0];
      REG_TAP_ZERO:    mirror_taps[0] = data;
      REG_TAP_ONE:     mirror_taps[1] = data;
      REG_TAP_TWO:     mirror_taps[2] = data;
      REG_TAP_THREE:   mirror_taps[3] = data;
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic func, input logic [BIN_W-1:0] bin,
                           input logic [AMP_W-1:0] amp, input bit typed,
                           input bin_result_t typed_res);
    bin_result_t res;
    @(negedge clk);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_bin_index <= bin;
    in_amplitude <= amp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_bin(func, bin, amp, res);
    pending_bins.push_back(typed ? typed_res : res);
  endtask

  // drop the input valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TAP_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, data);
  endtask

  task automatic drop_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned setting [7], input int count, input int read_pct);
    int          idx;
    int          n;
    int          pick;
    logic        func;
    logic [BIN_W-1:0] bin;
    logic [AMP_W-1:0] amp;
    settle();
    for (idx = REG_BINS_IN_USE; idx <= REG_TAP_THREE; idx++)
      write_reg(idx[CFG_IDX_W-1:0], setting[idx][TAP_W-1:0]);
    drop_cfg();
    for (int i = 0; i < count; i++) begin
      n = mirror_span();
      func = ($urandom_range(99) < read_pct) ? FUNC_READ : FUNC_UPDATE;
      if ($urandom_range(9) == 0) bin = BIN_W'($urandom_range(255));
      else bin = BIN_W'($urandom_range(n - 1));
      pick = $urandom_range(99);
      if (pick < 25) amp = '1;
      else if (pick < 35) amp = '0;
      else amp = AMP_W'($urandom_range(0, 24'hFFFFFF));
      send_word(func, bin, amp, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: result with none pending: bin_value %h saturated %b",
                 $time, out_bin_value, out_saturated);
        errors++;
      end else begin
        head_bin = pending_bins.pop_front();
        if (out_bin_value !== head_bin.value) begin
          $display("%0t: bin_value expected %h actual %h", $time, head_bin.value, out_bin_value);
          errors++;
        end
        if (out_saturated !== head_bin.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, head_bin.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("windowed_bin_bias_update_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned setting [7];
    int          p;
    int          idx;
    bit          reg_run;
    bin_result_t typed_res;

    for (idx = 0; idx < NUM_BINS; idx++) bias_mirror[idx] = '0;
    mirror_bins = NBINS_W'(NUM_BINS);
    mirror_wlen = WLEN_W'(1);
    mirror_periodic = 1'b0;
    mirror_taps[0] = TAP_W'(TAP_ONE_Q16);
    mirror_taps[1] = '0;
    mirror_taps[2] = '0;
    mirror_taps[3] = '0;
    reg_run = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (!reg_run) settle();
        write_reg(plan[r].sel[CFG_IDX_W-1:0], plan[r].arg[TAP_W-1:0]);
        reg_run = 1'b1;
      end else begin
        if (reg_run) drop_cfg();
        reg_run = 1'b0;
        typed_res.value = plan[r].val;
        typed_res.sat = plan[r].sat;
        send_word(plan[r].sel[0], plan[r].arg[BIN_W-1:0], plan[r].amp[AMP_W-1:0],
                  plan[r].typed, typed_res);
      end
    end
    if (reg_run) drop_cfg();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          setting[REG_BINS_IN_USE] = NUM_BINS;
          setting[REG_WINDOW_LEN] = MAX_TAPS;
          setting[REG_PERIODIC] = 1;
          for (idx = REG_TAP_ZERO; idx <= REG_TAP_THREE; idx++) setting[idx] = TAP_TOP;
        end
        1: begin
          // one bin, heavy centre tap: drive it into saturation
          setting[REG_BINS_IN_USE] = 1;
          setting[REG_WINDOW_LEN] = 7;
          setting[REG_PERIODIC] = 0;
          for (idx = REG_TAP_ZERO; idx <= REG_TAP_THREE; idx++) setting[idx] = TAP_TOP;
        end
        2: begin
          setting[REG_BINS_IN_USE] = 4;
          setting[REG_WINDOW_LEN] = MAX_TAPS;
          setting[REG_PERIODIC] = 1;
          for (idx = REG_TAP_ZERO; idx <= REG_TAP_THREE; idx++) setting[idx] = 0;
        end
        default: begin
          case ($urandom_range(5))
            0: setting[REG_BINS_IN_USE] = $urandom_range(0, 5);
            1: setting[REG_BINS_IN_USE] = $urandom_range(1, 16);
            2: setting[REG_BINS_IN_USE] = $urandom_range(17, NUM_BINS);
            3: setting[REG_BINS_IN_USE] = NUM_BINS;
            4: setting[REG_BINS_IN_USE] = $urandom_range(NUM_BINS + 1, 511);
            default: setting[REG_BINS_IN_USE] = $urandom_range(1, 8);
          endcase
          if ($urandom_range(3) == 0) setting[REG_WINDOW_LEN] = $urandom_range(0, 7);
          else setting[REG_WINDOW_LEN] = $urandom_range(2, MAX_TAPS);
          setting[REG_PERIODIC] = $urandom_range(1);
          for (idx = REG_TAP_ZERO; idx <= REG_TAP_THREE; idx++) begin
            case ($urandom_range(3))
              0: setting[idx] = TAP_ONE_Q16;
              1: setting[idx] = TAP_TOP;
              2: setting[idx] = $urandom_range(0, TAP_TOP);
              default: setting[idx] = $urandom_range(0, TAP_ONE_Q16);
            endcase
          end
        end
      endcase
      steady = (p == 5);
      run_phase(setting, PHASE_WORDS, (p == 1) ? 10 : 25);
    end
    steady = 1'b0;

    settle();
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("windowed_bin_bias_update_test: done, clean");
    else
      $display("windowed_bin_bias_update_test: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/wbbu_pkg.sv
rtl/wbbu_store.sv
rtl/windowed_bin_bias_update.sv
bench/windowed_bin_bias_update_test.sv
